// ----- sv/bba_pkg.sv -----
// Package for the bounding box accumulator: coordinate and item types,
// operation codes and box kinds. It depends on nothing else.
`default_nettype none

package bba_pkg;

  localparam int COORD_W = 32;
  localparam int AXES    = 3;
  localparam int TDATA_W = 2 * AXES * COORD_W;
  localparam int KIND_W  = 2;
  localparam int OP_W    = 2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [OP_W-1:0] {
    OP_MERGE_POINT  = 2'd0,
    OP_MERGE_BOX    = 2'd1,
    OP_CLEAR        = 2'd2,
    OP_SET_INFINITE = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_NULL     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INFINITE = 2'd2;

  typedef struct packed {
    op_t                   op;
    logic [KIND_W-1:0]     box_kind;
    coord_t [AXES-1:0]     lo;
    coord_t [AXES-1:0]     hi;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    coord_t [AXES-1:0]     lo;
    coord_t [AXES-1:0]     hi;
  } box_t;

endpackage

`default_nettype wire

// ----- sv/bba_in_stage.sv -----
// Input register of the bounding box accumulator: takes one request per cycle
// and holds it until the merge stage advances. Depends on bba_pkg.
`default_nettype none

module bba_in_stage
  import bba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,  // low_x, low_y, low_z, high_x, high_y, high_z
  input  wire logic [3:0]         in_tuser,  // operation, box_kind
  input  wire logic               advance,
  output      logic               item_valid,
  output      item_t              item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  item_t item_nxt;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    item_nxt.op       = op_t'(in_tuser[OP_W-1:0]);
    item_nxt.box_kind = in_tuser[OP_W +: KIND_W];
    for (int a = 0; a < AXES; a++) begin
      item_nxt.lo[a] = in_tdata[a*COORD_W +: COORD_W];
      item_nxt.hi[a] = in_tdata[(AXES+a)*COORD_W +: COORD_W];
    end
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bba_merge.sv -----
// Merge logic of the bounding box accumulator: next stored box and the
// accepted flag for one request. Depends on bba_pkg.
`default_nettype none

module bba_merge
  import bba_pkg::*;
(
  input  wire item_t cur_item,
  input  wire box_t  cur_box,
  output      box_t  next_box,
  output      logic  accepted
);

  always_comb begin
    next_box = cur_box;
    accepted = 1'b1;
    case (cur_item.op)
      OP_MERGE_POINT: begin
        if (cur_box.kind == KIND_NULL) begin
          next_box.kind = KIND_FINITE;
          next_box.lo   = cur_item.lo;
          next_box.hi   = cur_item.lo;
        end else if (cur_box.kind == KIND_FINITE) begin
          for (int a = 0; a < AXES; a++) begin
            if ($signed(cur_item.lo[a]) < $signed(cur_box.lo[a])) begin
              next_box.lo[a] = cur_item.lo[a];
            end
            if ($signed(cur_box.hi[a]) < $signed(cur_item.lo[a])) begin
              next_box.hi[a] = cur_item.lo[a];
            end
          end
        end
      end
      OP_MERGE_BOX: begin
        if (cur_box.kind == KIND_INFINITE || cur_item.box_kind == KIND_NULL ||
            (cur_item.box_kind != KIND_FINITE && cur_item.box_kind != KIND_INFINITE)) begin
          accepted = 1'b0;
        end else if (cur_item.box_kind == KIND_INFINITE) begin
          next_box      = '0;
          next_box.kind = KIND_INFINITE;
        end else if (cur_box.kind == KIND_NULL) begin
          next_box.kind = KIND_FINITE;
          next_box.lo   = cur_item.lo;
          next_box.hi   = cur_item.hi;
        end else begin
          for (int a = 0; a < AXES; a++) begin
            if ($signed(cur_item.lo[a]) < $signed(cur_box.lo[a])) begin
              next_box.lo[a] = cur_item.lo[a];
            end
            if ($signed(cur_box.hi[a]) < $signed(cur_item.hi[a])) begin
              next_box.hi[a] = cur_item.hi[a];
            end
          end
        end
      end
      OP_CLEAR: begin
        next_box      = '0;
        next_box.kind = KIND_NULL;
      end
      OP_SET_INFINITE: begin
        next_box      = '0;
        next_box.kind = KIND_INFINITE;
      end
      default: begin
        next_box = cur_box;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/bounding_box_accumulator.sv -----
// Bounding box accumulator: one request per clock cycle when the result side
// keeps up. An accepted request passes from the input register to the result register:
// the input register feeds a single compare-and-select stage against the stored
// box, whose outcome loads the stored box and the result register together.
// The result register decouples the two sides, so a new request is taken while
// an earlier result still waits. Corners read zero unless the kind is finite.
// Depends on bba_pkg, bba_in_stage and bba_merge.
`default_nettype none

module bounding_box_accumulator
  import bba_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // low_x, low_y, low_z, high_x, high_y, high_z
  input  wire logic [3:0]         in_tuser,   // operation, box_kind
  output      logic               out_tvalid,
  input  wire logic               out_tready,
  output      logic [TDATA_W-1:0] out_tdata,  // min_x, min_y, min_z, max_x, max_y, max_z
  output      logic [2:0]         out_tuser   // kind, accepted
);

  item_t              item;
  logic               item_valid;
  logic               advance;
  box_t               box_r;
  box_t               box_nxt;
  logic               accepted;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [TDATA_W-1:0] out_tdata_r;
  logic [TDATA_W-1:0] out_tdata_nxt;
  logic [2:0]         out_tuser_r;
  logic [2:0]         out_tuser_nxt;

  assign advance = item_valid && (!out_valid_r || out_tready);

  bba_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bba_merge u_merge (
    .cur_item (item),
    .cur_box  (box_r),
    .next_box (box_nxt),
    .accepted (accepted)
  );

  always_comb begin
    out_tdata_nxt = '0;
    if (box_nxt.kind == KIND_FINITE) begin
      for (int a = 0; a < AXES; a++) begin
        out_tdata_nxt[a*COORD_W +: COORD_W]        = box_nxt.lo[a];
        out_tdata_nxt[(AXES+a)*COORD_W +: COORD_W] = box_nxt.hi[a];
      end
    end
    out_tuser_nxt = {accepted, box_nxt.kind};
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      box_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        box_r <= box_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_tuser_r[KIND_W-1:0] == box_r.kind))
    else $error("Result kind differs from the stored kind.");

  a_corners_zero_unless_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r[KIND_W-1:0] != KIND_FINITE) |-> (out_tdata_r == '0))
    else $error("Non-finite result carries nonzero corners.");

  a_state_holds_without_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(box_r))
    else $error("Stored box changed without a request advancing.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> in_tready)
    else $error("Input stage is empty but not ready.");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for bounding_box_accumulator: directed and random requests
// against a tracked box, with random gaps and stalls on both stream channels.
// Depends on bba_pkg and bounding_box_accumulator.
`timescale 1ns / 100ps

module tb_top
  import bba_pkg::*;
();

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam coord_t COORD_LOW    = 32'sh8000_0000;
  localparam coord_t COORD_HIGH   = 32'sh7FFF_FFFF;
  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     RANDOM_ITEMS = 2000;
  localparam int     PHASE_LEN    = 250;
  localparam int     HOLD_CYCLES  = 300;

  typedef struct packed {
    logic                  accepted;
    logic [KIND_W-1:0]     kind;
    coord_t [AXES-1:0]     lo;
    coord_t [AXES-1:0]     hi;
  } box_report_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic [3:0]         in_tuser   = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [2:0]         out_tuser;

  logic [KIND_W-1:0] track_kind = KIND_NULL;
  coord_t            track_lo [AXES] = '{default: '0};
  coord_t            track_hi [AXES] = '{default: '0};
  box_report_t       pending_boxes [$];
  box_report_t       want;
  coord_t            got_lo, got_hi, want_lo, want_hi;
  string             axis_tag [AXES] = '{"x", "y", "z"};
  int                mismatches  = 0;
  int                cycle_count = 0;
  int                hold_left   = 0;
  int                stall_left  = 0;
  bit                gaps_on     = 1'b1;
  bit                stalls_on   = 1'b1;

  bounding_box_accumulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void zero_track();
    for (int a = 0; a < AXES; a++) begin
      track_lo[a] = '0;
      track_hi[a] = '0;
    end
  endfunction

  function automatic box_report_t advance_box(item_t req);
    box_report_t rpt;
    coord_t      p_lo, p_hi;
    rpt.accepted = 1'b1;
    case (req.op)
      OP_MERGE_POINT: begin
        for (int a = 0; a < AXES; a++) begin
          p_lo = req.lo[a];
          if (track_kind == KIND_NULL) begin
            track_lo[a] = p_lo;
            track_hi[a] = p_lo;
          end else if (track_kind == KIND_FINITE) begin
            if (p_lo < track_lo[a]) track_lo[a] = p_lo;
            if (p_lo > track_hi[a]) track_hi[a] = p_lo;
          end
        end
        if (track_kind == KIND_NULL) track_kind = KIND_FINITE;
      end
      OP_MERGE_BOX: begin
        if (track_kind == KIND_INFINITE || req.box_kind == KIND_NULL ||
            req.box_kind == KIND_UNUSED) begin
          rpt.accepted = 1'b0;
        end else if (req.box_kind == KIND_INFINITE) begin
          track_kind = KIND_INFINITE;
          zero_track();
        end else begin
          for (int a = 0; a < AXES; a++) begin
            p_lo = req.lo[a];
            p_hi = req.hi[a];
            if (track_kind == KIND_NULL) begin
              track_lo[a] = p_lo;
              track_hi[a] = p_hi;
            end else begin
              if (p_lo < track_lo[a]) track_lo[a] = p_lo;
              if (p_hi > track_hi[a]) track_hi[a] = p_hi;
            end
          end
          track_kind = KIND_FINITE;
        end
      end
      OP_CLEAR: begin
        track_kind = KIND_NULL;
        zero_track();
      end
      default: begin
        track_kind = KIND_INFINITE;
        zero_track();
      end
    endcase
    rpt.kind = track_kind;
    for (int a = 0; a < AXES; a++) begin
      rpt.lo[a] = (track_kind == KIND_FINITE) ? track_lo[a] : '0;
      rpt.hi[a] = (track_kind == KIND_FINITE) ? track_hi[a] : '0;
    end
    return rpt;
  endfunction

  function automatic item_t make_request(input op_t op, input logic [KIND_W-1:0] bk,
                                         input coord_t lx, ly, lz, hx, hy, hz);
    item_t req;
    req.op       = op;
    req.box_kind = bk;
    req.lo[0]    = lx;
    req.lo[1]    = ly;
    req.lo[2]    = lz;
    req.hi[0]    = hx;
    req.hi[1]    = hy;
    req.hi[2]    = hz;
    return req;
  endfunction

  function automatic coord_t random_coord();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return COORD_LOW;
    if (pick == 1) return COORD_HIGH;
    if (pick < 8) return coord_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    return coord_t'($urandom);
  endfunction

  function automatic item_t random_request();
    item_t  req;
    int     pick;
    coord_t base;
    pick = $urandom_range(0, 99);
    if (pick < 62) req.op = OP_MERGE_POINT;
    else if (pick < 85) req.op = OP_MERGE_BOX;
    else if (pick < 98) req.op = OP_CLEAR;
    else req.op = OP_SET_INFINITE;
    pick = $urandom_range(0, 19);
    if (pick < 16) req.box_kind = KIND_FINITE;
    else if (pick < 18) req.box_kind = KIND_NULL;
    else if (pick == 18) req.box_kind = KIND_INFINITE;
    else req.box_kind = KIND_UNUSED;
    for (int a = 0; a < AXES; a++) begin
      base = random_coord();
      req.lo[a] = base;
      if ($urandom_range(0, 7) == 0) req.hi[a] = random_coord();
      else req.hi[a] = base + coord_t'($urandom_range(0, 32'h0010_0000));
    end
    return req;
  endfunction

  task automatic send_request(input item_t req);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {req.hi, req.lo};
    in_tuser  <= {req.box_kind, req.op};
    do @(posedge clk); while (!in_tready);
    pending_boxes.push_back(advance_box(req));
  endtask

  task automatic drain_requests();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
  endtask

  task automatic test_point_merges();
    send_request(make_request(OP_MERGE_BOX, KIND_NULL, 5, 6, 7, 8, 9, 10));
    send_request(make_request(OP_MERGE_POINT, KIND_UNUSED, COORD_LOW, COORD_HIGH, 0,
                              COORD_HIGH, COORD_LOW, -1));
    send_request(make_request(OP_MERGE_POINT, KIND_NULL, COORD_HIGH, COORD_LOW, -1, 0, 0, 0));
    send_request(make_request(OP_MERGE_POINT, KIND_FINITE, 0, 0, 0, 1, 1, 1));
    send_request(make_request(OP_MERGE_POINT, KIND_INFINITE, -1, -1, -1, 0, 0, 0));
  endtask

  task automatic test_box_merges();
    send_request(make_request(OP_CLEAR, KIND_FINITE, 1, 1, 1, 1, 1, 1));
    send_request(make_request(OP_MERGE_BOX, KIND_FINITE, 100, -5, COORD_HIGH,
                              -100, -5, COORD_LOW));
    send_request(make_request(OP_MERGE_BOX, KIND_FINITE, COORD_LOW, 0, 0, COORD_HIGH, 0, 0));
    send_request(make_request(OP_MERGE_BOX, KIND_NULL, -9, -9, -9, 9, 9, 9));
    send_request(make_request(OP_MERGE_BOX, KIND_UNUSED, -9, -9, -9, 9, 9, 9));
    send_request(make_request(OP_MERGE_BOX, KIND_INFINITE, 3, 3, 3, 4, 4, 4));
    send_request(make_request(OP_MERGE_BOX, KIND_FINITE, 3, 3, 3, 4, 4, 4));
    send_request(make_request(OP_MERGE_POINT, KIND_FINITE, 7, 7, 7, 0, 0, 0));
    send_request(make_request(OP_MERGE_BOX, KIND_INFINITE, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_clear_and_infinite();
    send_request(make_request(OP_CLEAR, KIND_NULL, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_SET_INFINITE, KIND_NULL, 5, 5, 5, 5, 5, 5));
    send_request(make_request(OP_CLEAR, KIND_INFINITE, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_MERGE_POINT, KIND_NULL, 1, 2, 3, 0, 0, 0));
    send_request(make_request(OP_SET_INFINITE, KIND_FINITE, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_CLEAR, KIND_NULL, 0, 0, 0, 0, 0, 0));
    send_request(make_request(OP_MERGE_BOX, KIND_FINITE, -20, -30, -40, 20, 30, 40));
    send_request(make_request(OP_CLEAR, KIND_FINITE, 0, 0, 0, 0, 0, 0));
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // block fills up and must hold off its input side.
  task automatic test_output_hold();
    drain_requests();
    gaps_on   = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (40) send_request(random_request());
    drain_requests();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        drain_requests();
        gaps_on   = ((n / PHASE_LEN) % 3) != 1;
        stalls_on = ((n / PHASE_LEN) % 4) != 1;
      end
      send_request(random_request());
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!stalls_on || $urandom_range(0, 3) != 0) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_tready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_boxes.size() == 0) begin
        $error("result with no request pending: kind %0d", out_tuser[KIND_W-1:0]);
        mismatches++;
      end else begin
        want = pending_boxes.pop_front();
        if (out_tuser[KIND_W-1:0] !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser[KIND_W-1:0]);
          mismatches++;
        end
        if (out_tuser[KIND_W] !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, out_tuser[KIND_W]);
          mismatches++;
        end
        for (int a = 0; a < AXES; a++) begin
          got_lo  = out_tdata[a*COORD_W +: COORD_W];
          got_hi  = out_tdata[(a+AXES)*COORD_W +: COORD_W];
          want_lo = want.lo[a];
          want_hi = want.hi[a];
          if (got_lo !== want_lo) begin
            $error("min_%s: expected %0d, got %0d", axis_tag[a], want_lo, got_lo);
            mismatches++;
          end
          if (got_hi !== want_hi) begin
            $error("max_%s: expected %0d, got %0d", axis_tag[a], want_hi, got_hi);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_point_merges();
    test_box_merges();
    test_clear_and_infinite();
    test_output_hold();
    test_random_stream();
    drain_requests();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bba_pkg.sv
sv/bba_in_stage.sv
sv/bba_merge.sv
sv/bounding_box_accumulator.sv
verif/tb_top.sv
